FILE: hdl/bold_pkg.sv
// Package for the bounded ordered list deque: sizes, codes and word types.
`default_nettype none
package bold_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_FRONT = 3'd0,
    FUNC_INS_BACK  = 3'd1,
    FUNC_RM_FRONT  = 3'd2,
    FUNC_RM_BACK   = 3'd3,
    FUNC_RM_VALUE  = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [STAT_W-1:0]        status;
    logic                     is_empty;
    logic [OCC_W-1:0]         occupancy;
  } out_word_t;

  // Broadcast command to every cell; flags are already qualified by acceptance.
  typedef struct packed {
    logic                     shift_down;      // insert front: take left neighbor
    logic                     append;          // insert back: write at count
    logic                     shift_up;        // remove front: take right neighbor
    logic                     shift_up_match;  // remove by value: at or after first match
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     hit;   // first matching cell from the front
    logic                     last;  // backmost occupied cell
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: hdl/bold_cell.sv
// One list position: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module bold_cell (
  input  wire logic                             clk,
  input  wire logic [bold_pkg::IDX_W-1:0]       idx,
  input  wire bold_pkg::cell_cmd_t              cmd,
  input  wire logic signed [bold_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [bold_pkg::DATA_W-1:0] right_data,
  input  wire logic                             match_in,
  output logic                                  match_out,
  output bold_pkg::cell_stat_t                  stat
);

  logic signed [bold_pkg::DATA_W-1:0] data;
  logic signed [bold_pkg::DATA_W-1:0] data_next;
  logic [bold_pkg::CNT_W-1:0]         pos;
  logic                               occupied;
  logic                               at_count;
  logic                               mine;

  assign pos       = bold_pkg::CNT_W'(idx);
  assign occupied  = pos < cmd.count;
  assign at_count  = pos == cmd.count;
  assign mine      = occupied && (data == cmd.value);
  assign match_out = match_in || mine;

  assign stat.data = data;
  assign stat.hit  = mine && !match_in;
  assign stat.last = occupied && (pos == cmd.count - bold_pkg::CNT_W'(1));

  always_comb begin
    data_next = data;
    priority if (cmd.shift_down) begin
      data_next = left_data;
    end else if (cmd.append && at_count) begin
      data_next = cmd.value;
    end else if (cmd.shift_up) begin
      data_next = right_data;
    end else if (cmd.shift_up_match && match_out) begin
      data_next = right_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

FILE: hdl/bounded_ordered_list_deque.sv
// Top level of the bounded ordered list deque: cell row, control and result register.
//
// Usage:
//   The input channel carries request words (func, value); the output channel
//   returns one result word per request (removed_value, status, is_empty,
//   occupancy). Both use valid/stall: a word moves on a clock edge where valid
//   is high and stall is low.
//   Entries sit in a row of CAPACITY cells, front at cell 0. Each request is
//   handled in the cycle it is accepted: all cells compare against the value
//   at once, a ripple of match bits finds the first hit, and every cell loads
//   its own entry, a neighbor's entry or the request value in the same edge.
//   The result word is registered and valid in the cycle after acceptance, and
//   one request is taken every cycle while the receiver keeps up.
//   The result register is the only buffer: while a result is waiting and the
//   receiver stalls, the input stalls too; nothing is lost or repeated.
//   Reset empties the list and the result register; cell contents are left as
//   they are and only positions below the count are ever used.
`default_nettype none
module bounded_ordered_list_deque (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bold_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bold_pkg::out_word_t      out_data
);

  localparam int N = bold_pkg::CAPACITY;

  logic [bold_pkg::CNT_W-1:0]         count;
  logic [bold_pkg::CNT_W-1:0]         count_next;
  bold_pkg::cell_cmd_t                cmd;
  bold_pkg::cell_stat_t               stat [N];
  logic [N:0]                         match;
  logic [N-1:0]                       hits;
  logic signed [bold_pkg::DATA_W-1:0] back_val;
  logic signed [bold_pkg::DATA_W-1:0] hit_val;
  logic                               go;
  logic                               full;
  logic                               empty;
  logic                               found;
  bold_pkg::out_word_t                res;

  assign in_stall = out_valid && out_stall;
  assign go       = in_valid && !in_stall;
  assign full     = count == bold_pkg::CNT_W'(N);
  assign empty    = count == '0;
  assign match[0] = 1'b0;
  assign found    = match[N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [bold_pkg::DATA_W-1:0] left_d;
    logic signed [bold_pkg::DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_data.value;
    end else begin : g_mid_l
      assign left_d = stat[i-1].data;
    end
    if (i == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = stat[i+1].data;
    end
    bold_cell u_cell (
      .clk        (clk),
      .idx        (bold_pkg::IDX_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .match_in   (match[i]),
      .match_out  (match[i+1]),
      .stat       (stat[i])
    );
    assign hits[i] = stat[i].hit;
  end

  // At most one cell flags hit and at most one flags last, so OR selects.
  always_comb begin
    back_val = '0;
    hit_val  = '0;
    for (int k = 0; k < N; k++) begin
      back_val = back_val | (stat[k].last ? stat[k].data : '0);
      hit_val  = hit_val  | (stat[k].hit  ? stat[k].data : '0);
    end
  end

  always_comb begin
    cmd                   = '0;
    cmd.value             = in_data.value;
    cmd.count             = count;
    count_next            = count;
    res                   = '0;
    res.status            = bold_pkg::STAT_DONE;
    unique case (in_data.func)
      bold_pkg::FUNC_INS_FRONT: begin
        if (full) begin
          res.status = bold_pkg::STAT_FULL;
        end else begin
          cmd.shift_down = go;
          count_next     = count + bold_pkg::CNT_W'(1);
        end
      end
      bold_pkg::FUNC_INS_BACK: begin
        if (full) begin
          res.status = bold_pkg::STAT_FULL;
        end else begin
          cmd.append = go;
          count_next = count + bold_pkg::CNT_W'(1);
        end
      end
      bold_pkg::FUNC_RM_FRONT: begin
        if (empty) begin
          res.status = bold_pkg::STAT_EMPTY;
        end else begin
          cmd.shift_up      = go;
          res.removed_value = stat[0].data;
          count_next        = count - bold_pkg::CNT_W'(1);
        end
      end
      bold_pkg::FUNC_RM_BACK: begin
        if (empty) begin
          res.status = bold_pkg::STAT_EMPTY;
        end else begin
          res.removed_value = back_val;
          count_next        = count - bold_pkg::CNT_W'(1);
        end
      end
      bold_pkg::FUNC_RM_VALUE: begin
        if (found) begin
          cmd.shift_up_match = go;
          res.removed_value  = hit_val;
          count_next         = count - bold_pkg::CNT_W'(1);
        end else begin
          res.status = bold_pkg::STAT_EMPTY;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    res.is_empty  = count_next == '0;
    res.occupancy = bold_pkg::OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bold_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    go |=> (count == $past(count)) || (count == $past(count) + bold_pkg::CNT_W'(1)) ||
           (count + bold_pkg::CNT_W'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(count))
    else $error("entry count changed without an accepted request");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hits))
    else $error("more than one cell claims the first match");

endmodule
`default_nettype wire

FILE: sim/bounded_ordered_list_deque_tb.sv
// Self-checking testbench for the bounded ordered list deque, with a shadow-list predictor.
module bounded_ordered_list_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 925;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    bold_pkg::in_word_t word;
    bit                 wait_drain;  // hold this word back until every result is back
  } request_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bold_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bold_pkg::out_word_t out_data;

  bounded_ordered_list_deque DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  request_t            request_queue[$];
  bold_pkg::out_word_t result_queue[$];

  // Shadow copy of the list; position 0 is the front.
  logic signed [bold_pkg::DATA_W-1:0] shadow_list[bold_pkg::CAPACITY];
  int shadow_len = 0;

  int total_items = 0;
  int words_in = 0;
  int words_out = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int full_drops = 0;
  int misses = 0;
  int peak_occupancy = 0;
  request_t            next_req;
  bold_pkg::out_word_t want;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  // A long stretch in the middle of the run with no idling on either side.
  wire no_idle  = (words_in >= 400) && (words_in < 560);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [bold_pkg::DATA_W-1:0] take_entry(int pos);
    logic signed [bold_pkg::DATA_W-1:0] v;
    v = shadow_list[pos];
    for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return v;
  endfunction

  function automatic bold_pkg::out_word_t list_outcome(bold_pkg::in_word_t req);
    bold_pkg::out_word_t r;
    r = '0;
    r.status = bold_pkg::STAT_DONE;
    case (req.func)
      bold_pkg::FUNC_INS_FRONT: begin
        if (shadow_len >= bold_pkg::CAPACITY) begin
          r.status = bold_pkg::STAT_FULL;
        end else begin
          for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[0] = req.value;
          shadow_len++;
        end
      end
      bold_pkg::FUNC_INS_BACK: begin
        if (shadow_len >= bold_pkg::CAPACITY) begin
          r.status = bold_pkg::STAT_FULL;
        end else begin
          shadow_list[shadow_len] = req.value;
          shadow_len++;
        end
      end
      bold_pkg::FUNC_RM_FRONT, bold_pkg::FUNC_RM_BACK: begin
        if (shadow_len == 0) begin
          r.status = bold_pkg::STAT_EMPTY;
        end else begin
          r.removed_value = take_entry((req.func == bold_pkg::FUNC_RM_FRONT) ?
                                       0 : shadow_len - 1);
        end
      end
      bold_pkg::FUNC_RM_VALUE: begin
        r.status = bold_pkg::STAT_EMPTY;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == req.value) begin
            r.removed_value = take_entry(i);
            r.status = bold_pkg::STAT_DONE;
            break;
          end
        end
      end
      default: ;
    endcase
    r.is_empty  = (shadow_len == 0);
    r.occupancy = bold_pkg::OCC_W'(shadow_len);
    return r;
  endfunction

  task automatic add_request(logic [bold_pkg::FUNC_W-1:0] func,
                             logic signed [bold_pkg::DATA_W-1:0] value, bit wait_drain);
    request_t r;
    r.word.func  = func;
    r.word.value = value;
    r.wait_drain = wait_drain;
    request_queue.push_back(r);
    total_items++;
  endtask

  // Driver: presents queued words, holds each until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        result_queue.push_back(list_outcome(in_data));
        words_in <= words_in + 1;
      end
      if (!in_valid || in_fire) begin
        if (request_queue.size() > 0
            && !(request_queue[0].wait_drain && result_queue.size() > 0)
            && (no_idle || $urandom_range(99) >= 30)) begin
          next_req = request_queue.pop_front();
          in_data  <= next_req.word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        words_out <= words_out + 1;
        if (result_queue.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word removed=%0d status=%0d empty=%0b occ=%0d",
                   $realtime, out_data.removed_value, out_data.status, out_data.is_empty,
                   out_data.occupancy);
        end else begin
          want = result_queue.pop_front();
          if (want.status == bold_pkg::STAT_FULL) full_drops++;
          if (want.status == bold_pkg::STAT_EMPTY) misses++;
          if (want.occupancy > peak_occupancy) peak_occupancy = want.occupancy;
          if (out_data.removed_value !== want.removed_value || out_data.status !== want.status
              || out_data.is_empty !== want.is_empty
              || out_data.occupancy !== want.occupancy) begin
            error_count++;
            $display("%0t: mismatch expected %0d/%0d/%0b/%0d actual %0d/%0d/%0b/%0d",
                     $realtime, want.removed_value, want.status, want.is_empty,
                     want.occupancy, out_data.removed_value, out_data.status,
                     out_data.is_empty, out_data.occupancy);
          end
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 30);
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [bold_pkg::DATA_W-1:0] extremes[4];
    logic signed [bold_pkg::DATA_W-1:0] pool[8];
    logic [bold_pkg::FUNC_W-1:0] func;
    logic signed [bold_pkg::DATA_W-1:0] value;
    bit fill_phase;
    int roll;

    extremes[0] = 32'sh7FFF_FFFF;
    extremes[1] = 32'sh8000_0000;
    extremes[2] = -32'sd1;
    extremes[3] = 32'sd0;

    // Removals of every kind on an empty list.
    add_request(bold_pkg::FUNC_RM_FRONT, 0, 1'b0);
    add_request(bold_pkg::FUNC_RM_BACK, 0, 1'b0);
    add_request(bold_pkg::FUNC_RM_VALUE, 0, 1'b0);
    // Fill to capacity from both ends, with repeated values for first-match removal.
    for (int k = 0; k < bold_pkg::CAPACITY; k++)
      add_request((k % 2 == 0) ? bold_pkg::FUNC_INS_FRONT : bold_pkg::FUNC_INS_BACK,
                  (k < 4) ? extremes[k] : bold_pkg::DATA_W'(k % 5), 1'b0);
    add_request(bold_pkg::FUNC_INS_FRONT, 99, 1'b0);
    add_request(bold_pkg::FUNC_INS_BACK, 99, 1'b0);
    add_request(bold_pkg::FUNC_RM_VALUE, 2, 1'b0);
    add_request(bold_pkg::FUNC_RM_VALUE, 12345, 1'b0);
    // Codes past the last defined request leave the list alone.
    for (int c = bold_pkg::FUNC_RM_VALUE + 1; c < (1 << bold_pkg::FUNC_W); c++)
      add_request(bold_pkg::FUNC_W'(c), -1, 1'b0);
    add_request(bold_pkg::FUNC_RM_BACK, 0, 1'b0);
    add_request(bold_pkg::FUNC_RM_FRONT, 0, 1'b0);

    // A small pool of values keeps searches hitting and duplicates common.
    for (int k = 0; k < 4; k++) pool[k] = extremes[k];
    for (int k = 4; k < 8; k++) pool[k] = $urandom;
    fill_phase = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) fill_phase = $urandom_range(1);
      roll = $urandom_range(99);
      if (roll < 2)
        func = bold_pkg::FUNC_W'($urandom_range((1 << bold_pkg::FUNC_W) - 1,
                                                bold_pkg::FUNC_RM_VALUE + 1));
      else if (roll < (fill_phase ? 72 : 30))
        func = bold_pkg::FUNC_W'($urandom_range(bold_pkg::FUNC_INS_BACK,
                                                bold_pkg::FUNC_INS_FRONT));
      else
        func = bold_pkg::FUNC_W'($urandom_range(bold_pkg::FUNC_RM_VALUE,
                                                bold_pkg::FUNC_RM_FRONT));
      value = ($urandom_range(99) < 65) ? pool[$urandom_range(7)] : $urandom;
      add_request(func, value, (i == 300) || (i == 700));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (words_in < total_items || result_queue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests through the list: %0d inserts dropped on a full list,",
             words_in, full_drops);
    $display("%0d removals on an empty list or missed searches, peak occupancy %0d.",
             misses, peak_occupancy);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
